/* rtl/pdsm_pkg.sv */
// Shared types, codes and defaults of the packet delay statistics monitor.
`default_nettype none

package pdsm_pkg;

  localparam int DEF_COUNT_WIDTH = 32;
  localparam int DEF_TIMER_WIDTH = 20;

  localparam int DELAY_W = 20;
  localparam int APP_W   = 32;
  localparam int OUT_W   = 32;
  localparam int LIMIT_W = 16;
  localparam int PER_W   = 20;
  localparam int CFG_W   = 32;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_SLOW_THR  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STATS_PER = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BACK_PER  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOW_LIM  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_QWAIT_LIM = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_APP   = 3'd5;

  localparam logic [DELAY_W-1:0] RST_SLOW_THR  = 20'd28;
  localparam logic [PER_W-1:0]   RST_STATS_PER = 20'd2500;
  localparam logic [PER_W-1:0]   RST_BACK_PER  = 20'd900000;
  localparam logic [LIMIT_W-1:0] RST_SLOW_LIM  = 16'd10;
  localparam logic [LIMIT_W-1:0] RST_QWAIT_LIM = 16'd4000;
  localparam logic [APP_W-1:0]   RST_MIN_APP   = 32'd10000;

  localparam logic [1:0] MODE_PKT  = 2'd0;
  localparam logic [1:0] MODE_TICK = 2'd1;
  localparam logic [1:0] MODE_APP  = 2'd2;

  localparam logic [1:0] DIR_DL_IN = 2'd0;
  localparam logic [1:0] DIR_UL    = 2'd1;

  localparam int C_UL_PKT   = 0;
  localparam int C_UL_SLOW  = 1;
  localparam int C_DL_PKT   = 2;
  localparam int C_DL_SLOW  = 3;
  localparam int C_QWAIT    = 4;
  localparam int C_UL_UNREP = 5;
  localparam int C_DL_UNREP = 6;
  localparam int C_NUM      = 7;

  typedef struct packed {
    logic [1:0]         mode;
    logic [1:0]         direction;
    logic [DELAY_W-1:0] delay;
    logic [APP_W-1:0]   app_id;
  } in_word_t;

  typedef struct packed {
    logic [OUT_W-1:0] report_app;
    logic [OUT_W-1:0] ul_slow_count;
    logic [OUT_W-1:0] ul_packet_count;
    logic [OUT_W-1:0] ul_avg_delay;
    logic [OUT_W-1:0] dl_slow_count;
    logic [OUT_W-1:0] dl_packet_count;
    logic [OUT_W-1:0] dl_avg_delay;
    logic [OUT_W-1:0] queue_wait_count;
    logic [OUT_W-1:0] ul_unreported;
    logic [OUT_W-1:0] dl_unreported;
  } out_word_t;

endpackage

`default_nettype wire

/* rtl/pdsm_if.sv */
// Valid/ready channels for event words and report words.
`default_nettype none

interface pdsm_in_if
  import pdsm_pkg::*;
();
  logic     valid;
  logic     ready;
  in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface pdsm_out_if
  import pdsm_pkg::*;
();
  logic      valid;
  logic      ready;
  out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

/* rtl/packet_delay_stats_monitor.sv */
// Packet delay statistics monitor: counters, window timer and report builder.
// Packet, tick and app words are taken one per cycle while no report is built.
// A word that raises a report blocks the input while the bit-serial divider forms
// the two average delays and until the output register is free; the report then
// waits in an output register while new words are taken.
// Reset sets the registers to their defaults, the phase to idle and all counters to 0.
`default_nettype none

module packet_delay_stats_monitor
  import pdsm_pkg::*;
#(
  parameter int COUNT_WIDTH = DEF_COUNT_WIDTH,
  parameter int TIMER_WIDTH = DEF_TIMER_WIDTH
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_W-1:0]     cfg_data_i,
  pdsm_in_if.sink                   in_i,
  pdsm_out_if.source                out_o
);

  localparam int CW = COUNT_WIDTH;
  localparam int TW = TIMER_WIDTH;
  localparam int SW = ((CW > DELAY_W) ? CW : DELAY_W) + 1;
  localparam int LW = ((CW > LIMIT_W) ? CW : LIMIT_W) + 1;
  localparam int PW = (TW > PER_W) ? TW : PER_W;
  localparam logic [CW-1:0] CNT_MAX = {CW{1'b1}};
  localparam logic [TW-1:0] TMR_MAX = {TW{1'b1}};

  localparam logic [1:0] PH_IDLE    = 2'd0;
  localparam logic [1:0] PH_STATS   = 2'd1;
  localparam logic [1:0] PH_BACKOFF = 2'd2;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_DIV_UL = 2'd1;
  localparam logic [1:0] S_DIV_DL = 2'd2;
  localparam logic [1:0] S_HOLD   = 2'd3;

  logic [DELAY_W-1:0] slow_thr_q;
  logic [PER_W-1:0]   stats_per_q, back_per_q;
  logic [LIMIT_W-1:0] slow_lim_q, qwait_lim_q;
  logic [APP_W-1:0]   min_app_q;

  logic [1:0]       state_q, state_d;
  logic [1:0]       ph_q, ph_d;
  logic [TW-1:0]    tk_q, tk_d, tk_dec;
  logic [APP_W-1:0] last_q, last_d;
  logic [CW-1:0]    cnt_q [C_NUM];
  logic [CW-1:0]    cnt_d [C_NUM];
  logic [CW-1:0]    sum_q [2];
  logic [CW-1:0]    sum_d [2];

  out_word_t     stage_q, stage_d;
  out_word_t     out_q;
  logic          out_valid_q, out_valid_d, out_load;
  logic [CW-1:0] dl_sum_q, dl_sum_d, dl_cnt_q, dl_cnt_d;

  logic          acc, report, due, app_new;
  logic [CW:0]   both;
  logic [SW-1:0] delay_x;
  logic [SW-1:0] sum_x [2];
  logic [TW-1:0] stats_ld, back_ld;

  logic          div_start, div_done;
  logic [CW-1:0] div_dvd, div_dvs, div_quot;

  function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] v);
    return (v == CNT_MAX) ? v : v + 1'b1;
  endfunction

  function automatic logic [TW-1:0] clamp_per(input logic [PER_W-1:0] p);
    logic [PW-1:0] pw;
    pw = PW'(p);
    return (pw > PW'(TMR_MAX)) ? TMR_MAX : TW'(pw);
  endfunction

  assign acc = in_i.valid && in_i.ready;
  assign in_i.ready = state_q == S_IDLE;

  always_comb begin
    both    = {1'b0, cnt_q[C_UL_SLOW]} + {1'b0, cnt_q[C_DL_SLOW]};
    due     = LW'(both) > LW'(slow_lim_q) ||
              LW'(cnt_q[C_UL_SLOW]) > LW'(slow_lim_q) ||
              LW'(cnt_q[C_DL_SLOW]) > LW'(slow_lim_q) ||
              LW'(cnt_q[C_QWAIT]) > LW'(qwait_lim_q);
    app_new = in_i.data.app_id > min_app_q && in_i.data.app_id != last_q;
    delay_x = SW'(in_i.data.delay);
    for (int k = 0; k < 2; k++) begin
      sum_x[k] = SW'(sum_q[k]) + delay_x;
    end
    stats_ld = clamp_per(stats_per_q);
    back_ld  = clamp_per(back_per_q);
    tk_dec   = (tk_q != '0) ? tk_q - 1'b1 : tk_q;
  end

  always_comb begin
    ph_d   = ph_q;
    tk_d   = tk_q;
    last_d = last_q;
    cnt_d  = cnt_q;
    sum_d  = sum_q;
    report = 1'b0;
    if (acc) begin
      unique case (in_i.data.mode)
        MODE_PKT: begin
          if (in_i.data.direction == DIR_UL) begin
            cnt_d[C_UL_PKT] = sat_inc(cnt_q[C_UL_PKT]);
          end else if (in_i.data.direction == DIR_DL_IN) begin
            cnt_d[C_DL_PKT] = sat_inc(cnt_q[C_DL_PKT]);
          end
          if (in_i.data.delay >= slow_thr_q) begin
            if (ph_q == PH_IDLE && stats_per_q != '0) begin
              ph_d = PH_STATS;
              tk_d = stats_ld;
            end
            if (ph_q == PH_IDLE || ph_q == PH_STATS) begin
              if (in_i.data.direction == DIR_UL) begin
                cnt_d[C_UL_SLOW] = sat_inc(cnt_q[C_UL_SLOW]);
                sum_d[0] = (sum_x[0] > SW'(CNT_MAX)) ? CNT_MAX : CW'(sum_x[0]);
              end else if (in_i.data.direction == DIR_DL_IN) begin
                cnt_d[C_DL_SLOW] = sat_inc(cnt_q[C_DL_SLOW]);
                sum_d[1] = (sum_x[1] > SW'(CNT_MAX)) ? CNT_MAX : CW'(sum_x[1]);
              end else begin
                cnt_d[C_QWAIT] = sat_inc(cnt_q[C_QWAIT]);
              end
            end else if (ph_q == PH_BACKOFF) begin
              if (in_i.data.direction == DIR_UL) begin
                cnt_d[C_UL_UNREP] = sat_inc(cnt_q[C_UL_UNREP]);
              end else begin
                cnt_d[C_DL_UNREP] = sat_inc(cnt_q[C_DL_UNREP]);
              end
            end
          end
        end
        MODE_TICK: begin
          if (ph_q == PH_STATS || ph_q == PH_BACKOFF) begin
            tk_d = tk_dec;
            if (tk_dec == '0) begin
              ph_d = PH_IDLE;
              if (due) begin
                report = 1'b1;
                if (back_per_q != '0) begin
                  ph_d = PH_BACKOFF;
                  tk_d = back_ld;
                end
                for (int k = 0; k < C_NUM; k++) cnt_d[k] = '0;
                for (int k = 0; k < 2; k++) sum_d[k] = '0;
              end
            end
          end
        end
        MODE_APP: begin
          if (app_new) begin
            if (ph_q == PH_STATS) begin
              ph_d = PH_IDLE;
              tk_d = '0;
              if (due) begin
                report = 1'b1;
                if (back_per_q != '0) begin
                  ph_d = PH_BACKOFF;
                  tk_d = back_ld;
                end
              end
            end
            for (int k = 0; k < C_NUM; k++) cnt_d[k] = '0;
            for (int k = 0; k < 2; k++) sum_d[k] = '0;
            last_d = in_i.data.app_id;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    state_d   = state_q;
    stage_d   = stage_q;
    dl_sum_d  = dl_sum_q;
    dl_cnt_d  = dl_cnt_q;
    div_start = 1'b0;
    div_dvd   = sum_q[0];
    div_dvs   = cnt_q[C_UL_SLOW];
    out_load  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (report) begin
          div_start                = 1'b1;
          dl_sum_d                 = sum_q[1];
          dl_cnt_d                 = cnt_q[C_DL_SLOW];
          stage_d.report_app       = last_q;
          stage_d.ul_slow_count    = OUT_W'(cnt_q[C_UL_SLOW]);
          stage_d.ul_packet_count  = OUT_W'(cnt_q[C_UL_PKT]);
          stage_d.dl_slow_count    = OUT_W'(cnt_q[C_DL_SLOW]);
          stage_d.dl_packet_count  = OUT_W'(cnt_q[C_DL_PKT]);
          stage_d.queue_wait_count = OUT_W'(cnt_q[C_QWAIT]);
          stage_d.ul_unreported    = OUT_W'(cnt_q[C_UL_UNREP]);
          stage_d.dl_unreported    = OUT_W'(cnt_q[C_DL_UNREP]);
          state_d                  = S_DIV_UL;
        end
      end
      S_DIV_UL: begin
        div_dvd = dl_sum_q;
        div_dvs = dl_cnt_q;
        if (div_done) begin
          stage_d.ul_avg_delay = OUT_W'(div_quot);
          div_start            = 1'b1;
          state_d              = S_DIV_DL;
        end
      end
      S_DIV_DL: begin
        if (div_done) begin
          stage_d.dl_avg_delay = OUT_W'(div_quot);
          state_d              = S_HOLD;
        end
      end
      S_HOLD: begin
        if (!out_valid_q || out_o.ready) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    out_valid_d = out_load || (out_valid_q && !out_o.ready);
  end

  pdsm_div #(
    .W(CW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slow_thr_q  <= RST_SLOW_THR;
      stats_per_q <= RST_STATS_PER;
      back_per_q  <= RST_BACK_PER;
      slow_lim_q  <= RST_SLOW_LIM;
      qwait_lim_q <= RST_QWAIT_LIM;
      min_app_q   <= RST_MIN_APP;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SLOW_THR:  slow_thr_q  <= cfg_data_i[DELAY_W-1:0];
        CFG_STATS_PER: stats_per_q <= cfg_data_i[PER_W-1:0];
        CFG_BACK_PER:  back_per_q  <= cfg_data_i[PER_W-1:0];
        CFG_SLOW_LIM:  slow_lim_q  <= cfg_data_i[LIMIT_W-1:0];
        CFG_QWAIT_LIM: qwait_lim_q <= cfg_data_i[LIMIT_W-1:0];
        CFG_MIN_APP:   min_app_q   <= cfg_data_i[APP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ph_q        <= PH_IDLE;
      tk_q        <= '0;
      last_q      <= '0;
      out_valid_q <= 1'b0;
      for (int k = 0; k < C_NUM; k++) cnt_q[k] <= '0;
      for (int k = 0; k < 2; k++) sum_q[k] <= '0;
    end else begin
      state_q     <= state_d;
      ph_q        <= ph_d;
      tk_q        <= tk_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
      sum_q       <= sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    stage_q  <= stage_d;
    dl_sum_q <= dl_sum_d;
    dl_cnt_q <= dl_cnt_d;
    if (out_load) begin
      out_q <= stage_q;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  a_report_starts_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    report |=> state_q == S_DIV_UL)
    else $error("report did not start the divider");

  a_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_DIV_UL || state_q == S_DIV_DL))
    else $error("divider finished outside a division state");

  a_phase_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ph_q != 2'd3)
    else $error("phase left its three values");

  a_out_from_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == S_HOLD)
    else $error("report word raised outside hold");

endmodule

`default_nettype wire

/* rtl/pdsm_div.sv */
// Bit-serial restoring divider, one quotient bit per cycle.
`default_nettype none

module pdsm_div
  import pdsm_pkg::*;
#(
  parameter int W = DEF_COUNT_WIDTH
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         start_i,
  input  wire logic [W-1:0] dividend_i,
  input  wire logic [W-1:0] divisor_i,
  output logic              done_o,
  output logic [W-1:0]      quot_o
);

  localparam int IW = $clog2(W);

  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [IW-1:0] iter_q, iter_d;
  logic [W-1:0]  rem_q, rem_d;
  logic [W-1:0]  dvd_q, dvd_d;
  logic [W-1:0]  dvs_q, dvs_d;
  logic          zero_q, zero_d;
  logic [W:0]    trial;
  logic          fits;

  always_comb begin
    trial  = {rem_q, dvd_q[W-1]};
    fits   = trial >= {1'b0, dvs_q};
    busy_d = busy_q;
    done_d = 1'b0;
    iter_d = iter_q;
    rem_d  = rem_q;
    dvd_d  = dvd_q;
    dvs_d  = dvs_q;
    zero_d = zero_q;
    if (start_i) begin
      busy_d = 1'b1;
      iter_d = IW'(W - 1);
      rem_d  = '0;
      dvd_d  = dividend_i;
      dvs_d  = divisor_i;
      zero_d = divisor_i == '0;
    end else if (busy_q) begin
      rem_d = fits ? W'(trial - {1'b0, dvs_q}) : trial[W-1:0];
      dvd_d = {dvd_q[W-2:0], fits};
      if (iter_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        iter_d = iter_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      iter_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      iter_q <= iter_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    dvd_q  <= dvd_d;
    dvs_q  <= dvs_d;
    zero_q <= zero_d;
  end

  assign done_o = done_q;
  assign quot_o = zero_q ? '0 : dvd_q;

endmodule

`default_nettype wire

/* dv/pdsm_checker.sv */
// Checker that mirrors the monitor's counters and timer and compares every report word.
`timescale 1ns / 1ps

module pdsm_checker
  import pdsm_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic                 in_valid_i,
  input  logic                 in_ready_i,
  input  in_word_t             in_data_i,
  input  logic                 out_valid_i,
  input  logic                 out_ready_i,
  input  out_word_t            out_data_i,
  output int                   errors_o,
  output int                   pending_o,
  output int                   reports_o
);

  localparam int CNT_W    = DEF_COUNT_WIDTH;
  localparam int N_FIELDS = 10;
  localparam int MAX_LINES = 100;

  localparam logic [1:0] PH_IDLE    = 2'd0;
  localparam logic [1:0] PH_STATS   = 2'd1;
  localparam logic [1:0] PH_BACKOFF = 2'd2;

  string field_names [N_FIELDS] = '{
    "report_app", "ul_slow_count", "ul_packet_count", "ul_avg_delay", "dl_slow_count",
    "dl_packet_count", "dl_avg_delay", "queue_wait_count", "ul_unreported", "dl_unreported"
  };

  logic [DELAY_W-1:0] slow_thr;
  logic [PER_W-1:0]   stats_per;
  logic [PER_W-1:0]   back_per;
  logic [LIMIT_W-1:0] slow_lim;
  logic [LIMIT_W-1:0] qwait_lim;
  logic [APP_W-1:0]   min_app;

  logic [1:0]         phase;
  logic [PER_W-1:0]   ticks_left;
  logic [APP_W-1:0]   last_app;
  logic [CNT_W-1:0]   counts [C_NUM];
  logic [CNT_W-1:0]   sums [2];

  out_word_t expected_reports [$];
  out_word_t got_rep;
  out_word_t exp_rep;
  out_word_t new_rep;

  function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                               input logic [CNT_W-1:0] b);
    logic [CNT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CNT_W] ? '1 : s[CNT_W-1:0];
  endfunction

  function automatic void bump(input int idx);
    counts[idx] = sat_add(counts[idx], CNT_W'(1));
  endfunction

  function automatic void clear_counts();
    for (int i = 0; i < C_NUM; i++) counts[i] = '0;
    sums[0] = '0;
    sums[1] = '0;
  endfunction

  function automatic void start_timer(input logic [1:0] ph, input logic [PER_W-1:0] period);
    if (period == 0 || phase != PH_IDLE) return;
    ticks_left = period;
    phase = ph;
  endfunction

  function automatic bit report_due();
    logic [CNT_W:0] both;
    both = {1'b0, counts[C_UL_SLOW]} + {1'b0, counts[C_DL_SLOW]};
    return both > slow_lim || counts[C_UL_SLOW] > slow_lim ||
           counts[C_DL_SLOW] > slow_lim || counts[C_QWAIT] > qwait_lim;
  endfunction

  function automatic logic [OUT_W-1:0] avg_delay(input logic [CNT_W-1:0] sum,
                                                 input logic [CNT_W-1:0] cnt);
    return (cnt == 0) ? '0 : OUT_W'(sum / cnt);
  endfunction

  function automatic out_word_t build_report();
    out_word_t r;
    r.report_app       = last_app;
    r.ul_slow_count    = OUT_W'(counts[C_UL_SLOW]);
    r.ul_packet_count  = OUT_W'(counts[C_UL_PKT]);
    r.ul_avg_delay     = avg_delay(sums[0], counts[C_UL_SLOW]);
    r.dl_slow_count    = OUT_W'(counts[C_DL_SLOW]);
    r.dl_packet_count  = OUT_W'(counts[C_DL_PKT]);
    r.dl_avg_delay     = avg_delay(sums[1], counts[C_DL_SLOW]);
    r.queue_wait_count = OUT_W'(counts[C_QWAIT]);
    r.ul_unreported    = OUT_W'(counts[C_UL_UNREP]);
    r.dl_unreported    = OUT_W'(counts[C_DL_UNREP]);
    return r;
  endfunction

  function automatic void count_slow(input logic [1:0] dir, input logic [DELAY_W-1:0] dly);
    if (dir == DIR_UL) begin
      bump(C_UL_SLOW);
      sums[0] = sat_add(sums[0], CNT_W'(dly));
    end else if (dir == DIR_DL_IN) begin
      bump(C_DL_SLOW);
      sums[1] = sat_add(sums[1], CNT_W'(dly));
    end else begin
      bump(C_QWAIT);
    end
  endfunction

  function automatic bit predict_report(input in_word_t w, output out_word_t rep);
    bit due;
    rep = '0;
    due = 1'b0;
    case (w.mode)
      MODE_PKT: begin
        if (w.direction == DIR_UL) bump(C_UL_PKT);
        else if (w.direction == DIR_DL_IN) bump(C_DL_PKT);
        if (w.delay >= slow_thr) begin
          if (phase == PH_IDLE) begin
            start_timer(PH_STATS, stats_per);
            count_slow(w.direction, w.delay);
          end else if (phase == PH_STATS) begin
            count_slow(w.direction, w.delay);
          end else if (phase == PH_BACKOFF) begin
            if (w.direction == DIR_UL) bump(C_UL_UNREP);
            else bump(C_DL_UNREP);
          end
        end
      end
      MODE_TICK: begin
        if (phase == PH_STATS || phase == PH_BACKOFF) begin
          if (ticks_left != 0) ticks_left--;
          if (ticks_left == 0) begin
            phase = PH_IDLE;
            if (report_due()) begin
              rep = build_report();
              start_timer(PH_BACKOFF, back_per);
              clear_counts();
              due = 1'b1;
            end
          end
        end
      end
      MODE_APP: begin
        if (w.app_id > min_app && w.app_id != last_app) begin
          if (phase == PH_STATS) begin
            phase = PH_IDLE;
            ticks_left = '0;
            if (report_due()) begin
              rep = build_report();
              start_timer(PH_BACKOFF, back_per);
              due = 1'b1;
            end
          end
          clear_counts();
          last_app = w.app_id;
        end
      end
      default: ;
    endcase
    return due;
  endfunction

  task automatic flag_error(input string msg);
    if (errors_o < MAX_LINES) $display("MISMATCH: %s", msg);
    errors_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slow_thr   = RST_SLOW_THR;
      stats_per  = RST_STATS_PER;
      back_per   = RST_BACK_PER;
      slow_lim   = RST_SLOW_LIM;
      qwait_lim  = RST_QWAIT_LIM;
      min_app    = RST_MIN_APP;
      phase      = PH_IDLE;
      ticks_left = '0;
      last_app   = '0;
      clear_counts();
      expected_reports.delete();
      errors_o   = 0;
      reports_o  = 0;
      pending_o  = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_SLOW_THR:  slow_thr  = cfg_data_i[DELAY_W-1:0];
          CFG_STATS_PER: stats_per = cfg_data_i[PER_W-1:0];
          CFG_BACK_PER:  back_per  = cfg_data_i[PER_W-1:0];
          CFG_SLOW_LIM:  slow_lim  = cfg_data_i[LIMIT_W-1:0];
          CFG_QWAIT_LIM: qwait_lim = cfg_data_i[LIMIT_W-1:0];
          CFG_MIN_APP:   min_app   = cfg_data_i[APP_W-1:0];
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        reports_o++;
        got_rep = out_data_i;
        if (expected_reports.size() == 0) begin
          flag_error($sformatf("unexpected report word for app %0d", got_rep.report_app));
        end else begin
          exp_rep = expected_reports.pop_front();
          for (int i = 0; i < N_FIELDS; i++) begin
            if (got_rep[(N_FIELDS-1-i)*OUT_W +: OUT_W] !== exp_rep[(N_FIELDS-1-i)*OUT_W +: OUT_W])
              flag_error($sformatf("report %0d field %s: got %0d, want %0d", reports_o,
                         field_names[i], got_rep[(N_FIELDS-1-i)*OUT_W +: OUT_W],
                         exp_rep[(N_FIELDS-1-i)*OUT_W +: OUT_W]));
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        if (predict_report(in_data_i, new_rep)) expected_reports.push_back(new_rep);
      end
      pending_o = expected_reports.size();
    end
  end

endmodule

/* dv/tb.sv */
// Testbench top for the packet delay statistics monitor: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb;
  import pdsm_pkg::*;

  localparam logic [1:0] MODE_NONE  = 2'd3;
  localparam logic [1:0] DIR_DL_OUT = 2'd2;
  localparam logic [1:0] DIR_ALT    = 2'd3;

  localparam int IDLE_SPLIT = 0;
  localparam int IDLE_SWAP  = 1;
  localparam int IDLE_OFF   = 2;

  localparam int STALL_LIMIT   = 4000;
  localparam int SETTLE_CYCLES = 100;
  localparam int HOLD_CYCLES   = 600;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]     cfg_data;

  pdsm_in_if  in_ch ();
  pdsm_out_if out_ch ();

  int errors;
  int pending;
  int reports;
  int idle_sel;
  logic pressure_on;
  int words_sent;
  logic [DELAY_W-1:0] cur_thr;
  logic [APP_W-1:0]   cur_min_app;

  packet_delay_stats_monitor dut (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data),
    .in_i      (in_ch),
    .out_o     (out_ch)
  );

  pdsm_checker chk (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_valid_i (in_ch.valid),
    .in_ready_i (in_ch.ready),
    .in_data_i  (in_ch.data),
    .out_valid_i(out_ch.valid),
    .out_ready_i(out_ch.ready),
    .out_data_i (out_ch.data),
    .errors_o   (errors),
    .pending_o  (pending),
    .reports_o  (reports)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic in_word_t make_word(input logic [1:0] mode, input logic [1:0] dir,
                                         input logic [DELAY_W-1:0] dly,
                                         input logic [APP_W-1:0] app);
    in_word_t w;
    w.mode      = mode;
    w.direction = dir;
    w.delay     = dly;
    w.app_id    = app;
    return w;
  endfunction

  function automatic in_word_t random_word();
    in_word_t w;
    int pick;
    int unsigned nd;
    pick = $urandom_range(0, 99);
    if (pick < 55) w.mode = MODE_PKT;
    else if (pick < 90) w.mode = MODE_TICK;
    else if (pick < 98) w.mode = MODE_APP;
    else w.mode = MODE_NONE;
    w.direction = 2'($urandom_range(0, 3));
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      nd = cur_thr + $urandom_range(0, 4);
      nd = (nd < 2) ? 0 : nd - 2;
      if (nd > 20'hFFFFF) nd = 20'hFFFFF;
      w.delay = DELAY_W'(nd);
    end else if (pick < 60) begin
      w.delay = '1;
    end else if (pick < 70) begin
      w.delay = '0;
    end else begin
      w.delay = DELAY_W'($urandom);
    end
    pick = $urandom_range(0, 99);
    if (pick < 50) w.app_id = cur_min_app + APP_W'($urandom_range(1, 4));
    else if (pick < 65) w.app_id = cur_min_app;
    else w.app_id = $urandom;
    return w;
  endfunction

  task automatic send_word(input in_word_t w);
    int gap_pct;
    gap_pct = (idle_sel == IDLE_SPLIT) ? 22 : (idle_sel == IDLE_SWAP) ? 49 : 0;
    @(negedge clk);
    while ($urandom_range(0, 99) < gap_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= w;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    words_sent++;
  endtask

  task automatic run_random(input int n);
    repeat (n) send_word(random_word());
  endtask

  task automatic settle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value;
  endtask

  task automatic set_config(input logic [DELAY_W-1:0] thr, input logic [PER_W-1:0] stats,
                            input logic [PER_W-1:0] backoff, input logic [LIMIT_W-1:0] slim,
                            input logic [LIMIT_W-1:0] qlim, input logic [APP_W-1:0] min_app);
    settle();
    write_reg(CFG_SLOW_THR,  CFG_W'(thr));
    write_reg(CFG_STATS_PER, CFG_W'(stats));
    write_reg(CFG_BACK_PER,  CFG_W'(backoff));
    write_reg(CFG_SLOW_LIM,  CFG_W'(slim));
    write_reg(CFG_QWAIT_LIM, CFG_W'(qlim));
    write_reg(CFG_MIN_APP,   CFG_W'(min_app));
    @(negedge clk);
    cfg_we <= 1'b0;
    cur_thr     = thr;
    cur_min_app = min_app;
  endtask

  // receiver: random stalls, plus one long hold-off once pressure is requested
  initial begin
    int hold_left;
    bit held;
    hold_left = 0;
    held = 1'b0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (pressure_on && !held) begin
        held = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= $urandom_range(0, 99) >=
                        ((idle_sel == IDLE_SPLIT) ? 49 : (idle_sel == IDLE_SWAP) ? 22 : 0);
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data  = '0;
    cfg_we      = 1'b0;
    cfg_idx     = '0;
    cfg_data    = '0;
    rst_n       = 1'b0;
    idle_sel    = IDLE_SPLIT;
    pressure_on = 1'b0;
    words_sent  = 0;
    cur_thr     = RST_SLOW_THR;
    cur_min_app = RST_MIN_APP;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    set_config(20'd28, 20'd3, 20'd2, 16'd0, 16'd0, 32'd10000);
    send_word(make_word(MODE_APP, DIR_UL, '0, 32'd10000));
    send_word(make_word(MODE_APP, DIR_UL, '0, 32'd10001));
    send_word(make_word(MODE_APP, DIR_UL, '0, 32'd10001));
    send_word(make_word(MODE_PKT, DIR_UL, 20'd27, '0));
    send_word(make_word(MODE_PKT, DIR_UL, 20'd28, '0));
    send_word(make_word(MODE_PKT, DIR_DL_IN, '1, '0));
    send_word(make_word(MODE_PKT, DIR_DL_OUT, 20'd100, '0));
    send_word(make_word(MODE_PKT, DIR_ALT, 20'd28, '0));
    send_word(make_word(MODE_NONE, 2'($urandom), DELAY_W'($urandom), $urandom));
    repeat (3) send_word(make_word(MODE_TICK, DIR_UL, '0, '0));
    send_word(make_word(MODE_PKT, DIR_UL, 20'd500, '0));
    send_word(make_word(MODE_PKT, DIR_DL_OUT, 20'd30, '0));
    repeat (2) send_word(make_word(MODE_TICK, DIR_UL, '0, '0));
    send_word(make_word(MODE_TICK, DIR_UL, '0, '0));
    send_word(make_word(MODE_PKT, DIR_DL_IN, 20'd28, '0));
    send_word(make_word(MODE_APP, DIR_UL, '0, '1));
    send_word(make_word(MODE_PKT, DIR_UL, '0, '0));
    repeat (2) send_word(make_word(MODE_TICK, DIR_UL, '0, '0));
    send_word(make_word(MODE_APP, DIR_UL, '0, '0));

    set_config(20'd100, 20'd6, 20'd4, 16'd2, 16'd3, 32'd1000);
    run_random(200);
    set_config(20'd0, 20'd1, 20'd1, 16'd0, 16'd0, 32'd0);
    run_random(200);

    idle_sel = IDLE_SWAP;
    set_config(20'd50, 20'd8, 20'd0, 16'd1, 16'd0, 32'hFFFF_FFFE);
    run_random(200);
    set_config(20'hFFFFF, 20'd0, 20'd5, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
    run_random(60);

    idle_sel = IDLE_OFF;
    set_config(20'd0, 20'd2, 20'd1, 16'd0, 16'd0, 32'd0);
    pressure_on = 1'b1;
    run_random(200);

    // drain any open window or backoff, then load the uplink delay sum with full-scale delays
    set_config(20'd0, 20'hFFFFF, 20'd3, 16'd30, 16'hFFFF, 32'd100);
    repeat (6) send_word(make_word(MODE_TICK, DIR_UL, '0, '0));
    repeat (40) send_word(make_word(MODE_PKT, DIR_UL, '1, '0));
    repeat (3) send_word(make_word(MODE_PKT, DIR_DL_IN, '1, '0));
    send_word(make_word(MODE_APP, DIR_UL, '0, 32'h7000_0001));
    run_random(60);

    set_config(20'd1, 20'd4, 20'hFFFFF, 16'd0, 16'd0, 32'd5);
    run_random(100);

    settle();
    $display("Run covered %0d event words and %0d report words over eight register settings,",
             words_sent, reports);
    $display("with zero and full-scale periods and delays, backoff and a long output hold.");
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
